// ===== hdl/vector3_alu_top_defines.svh =====
`ifndef VECTOR3_ALU_TOP_DEFINES_SVH
`define VECTOR3_ALU_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define V3A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define V3A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/v3a_pkg.sv =====
package v3a_pkg;

	localparam int CMD_W = 3;

	// operation codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DOT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SCALE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LEN   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NORM  = 3'd5;

	// control group handed from the front stages to the rest of the pipe
	typedef struct packed {
		logic             vld;
		logic [CMD_W-1:0] cmd;
		logic             fault;
	} ctl_t;

endpackage

// ===== hdl/v3a_front.sv =====
module v3a_front import v3a_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [CMD_W-1:0]    cmd,
	input  logic signed [W-1:0] a [3],
	input  logic signed [W-1:0] b [3],
	input  logic signed [W-1:0] s,
	output ctl_t                ctl,
	output logic signed [W-1:0] r [3],
	output logic signed [W-1:0] sc,
	output logic [2*W-1:0]      sq,
	output logic [W-1:0]        mag [3],
	output logic [2:0]          sgn
);

	localparam int SW = 2*W + 2;

	// saturate a wide signed value to W bits, flag in the top bit
	function automatic logic [W:0] sat_f(input logic signed [SW-1:0] v);
		logic         ovf;
		logic [W-1:0] res;
		ovf = (v[SW-1:W-1] != {(SW-W+1){v[SW-1]}});
		if (!ovf) begin
			res = v[W-1:0];
		end else if (v[SW-1]) begin
			res = {1'b1, {(W-1){1'b0}}};
		end else begin
			res = {1'b0, {(W-1){1'b1}}};
		end
		return {ovf, res};
	endfunction

	logic                  vld_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic signed [W-1:0]   a_s1 [3];
	logic signed [2*W-1:0] prod_s1 [3];
	logic signed [W:0]     as_s1 [3];

	logic signed [W-1:0]   opnd [3];
	logic signed [2*W-1:0] prod [3];
	logic signed [W:0]     as_c [3];

	// stage 1: one multiplier per lane, operand picked by command; add or subtract
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd)
				CMD_DOT:   opnd[i] = b[i];
				CMD_SCALE: opnd[i] = s;
				default:   opnd[i] = a[i];
			endcase
			prod[i] = a[i] * opnd[i];
			if (cmd == CMD_SUB) begin
				as_c[i] = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
			end else begin
				as_c[i] = {a[i][W-1], a[i]} + {b[i][W-1], b[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]    <= a[i];
				prod_s1[i] <= prod[i];
				as_s1[i]   <= as_c[i];
			end
		end
	end

	// stage 2: sums, floor shifts and saturation
	logic signed [SW-1:0] pe [3];
	logic signed [SW-1:0] pe_sh [3];
	logic signed [SW-1:0] ase [3];
	logic signed [SW-1:0] dot_sum;
	logic signed [SW-1:0] dot_sh;
	logic [W:0]           as_sat [3];
	logic [W:0]           scl_sat [3];
	logic [W:0]           dot_sat;
	logic [2*W-1:0]       sq_c;
	logic [W-1:0]         mag_c [3];
	logic signed [W-1:0]  r_c [3];
	logic signed [W-1:0]  sc_c;
	logic                 flt_c;
	logic                 vld_s2;
	logic [CMD_W-1:0]     cmd_s2;
	logic                 flt_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pe[i]      = {{2{prod_s1[i][2*W-1]}}, prod_s1[i]};
			pe_sh[i]   = pe[i] >>> F;
			ase[i]     = {{(SW-W-1){as_s1[i][W]}}, as_s1[i]};
			as_sat[i]  = sat_f(ase[i]);
			scl_sat[i] = sat_f(pe_sh[i]);
			mag_c[i]   = a_s1[i][W-1] ? (~a_s1[i] + 1'b1) : a_s1[i];
		end
		dot_sum = pe[0] + pe[1] + pe[2];
		dot_sh  = dot_sum >>> F;
		dot_sat = sat_f(dot_sh);
		sq_c    = prod_s1[0] + prod_s1[1] + prod_s1[2];

		for (int i = 0; i < 3; i++) begin
			r_c[i] = '0;
		end
		sc_c  = '0;
		flt_c = 1'b0;
		case (cmd_s1)
			CMD_ADD, CMD_SUB: begin
				for (int i = 0; i < 3; i++) begin
					r_c[i] = as_sat[i][W-1:0];
				end
				flt_c = as_sat[0][W] | as_sat[1][W] | as_sat[2][W];
			end
			CMD_DOT: begin
				sc_c  = dot_sat[W-1:0];
				flt_c = dot_sat[W];
			end
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					r_c[i] = scl_sat[i][W-1:0];
				end
				flt_c = scl_sat[0][W] | scl_sat[1][W] | scl_sat[2][W];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			flt_s2 <= flt_c;
			sc     <= sc_c;
			sq     <= sq_c;
			for (int i = 0; i < 3; i++) begin
				r[i]   <= r_c[i];
				mag[i] <= mag_c[i];
				sgn[i] <= a_s1[i][W-1];
			end
		end
	end

	assign ctl = {vld_s2, cmd_s2, flt_s2};

endmodule

// ===== hdl/v3a_sqrt.sv =====
module v3a_sqrt #(
	parameter int W  = 32,
	parameter int TW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  logic [2*W-1:0] n_in,
	input  logic [TW-1:0]  tag_in,
	output logic           vld_out,
	output logic [W-1:0]   root_out,
	output logic [TW-1:0]  tag_out
);

	// one root bit per stage, W stages
	logic           vld_s  [W];
	logic [W:0]     rem_s  [W];
	logic [W-1:0]   root_s [W];
	logic [2*W-1:0] n_s    [W];
	logic [TW-1:0]  tag_s  [W];

	genvar k;
	generate
		for (k = 0; k < W; k++) begin : g_stage
			logic           vld_c;
			logic [W:0]     rem_c;
			logic [W-1:0]   root_c;
			logic [2*W-1:0] n_c;
			logic [TW-1:0]  tag_c;
			logic [W+2:0]   r2;
			logic [W+2:0]   trial;
			logic [W+2:0]   diff;
			logic           ge;

			if (k == 0) begin : g_first
				assign vld_c  = vld_in;
				assign rem_c  = '0;
				assign root_c = '0;
				assign n_c    = n_in;
				assign tag_c  = tag_in;
			end else begin : g_next
				assign vld_c  = vld_s[k-1];
				assign rem_c  = rem_s[k-1];
				assign root_c = root_s[k-1];
				assign n_c    = n_s[k-1];
				assign tag_c  = tag_s[k-1];
			end

			// bring down two radicand bits, try root*4+1
			assign r2    = {rem_c, n_c[2*W-1 -: 2]};
			assign trial = {1'b0, root_c, 2'b01};
			assign diff  = r2 - trial;
			assign ge    = (r2 >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_c;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? diff[W:0] : r2[W:0];
					root_s[k] <= {root_c[W-2:0], ge};
					n_s[k]    <= {n_c[2*W-3:0], 2'b00};
					tag_s[k]  <= tag_c;
				end
			end
		end
	endgenerate

	assign vld_out  = vld_s[W-1];
	assign root_out = root_s[W-1];
	assign tag_out  = tag_s[W-1];

endmodule

// ===== hdl/v3a_div.sv =====
module v3a_div #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [W-1:0]  den_in,
	input  logic [W-1:0]  num_in [3],
	input  logic [TW-1:0] tag_in,
	output logic          vld_out,
	output logic [F:0]    quo_out [3],
	output logic [TW-1:0] tag_out
);

	// restoring divide of (num << F) by den, num <= den, one quotient bit per stage
	localparam int D = F + 1;

	logic          vld_s [D];
	logic [W-1:0]  den_s [D];
	logic [W-1:0]  rem_s [D][3];
	logic [F:0]    q_s   [D][3];
	logic [TW-1:0] tag_s [D];

	genvar j, l;
	generate
		for (j = 0; j < D; j++) begin : g_stage
			logic          vld_c;
			logic [W-1:0]  den_c;
			logic [TW-1:0] tag_c;

			if (j == 0) begin : g_first
				assign vld_c = vld_in;
				assign den_c = den_in;
				assign tag_c = tag_in;
			end else begin : g_next
				assign vld_c = vld_s[j-1];
				assign den_c = den_s[j-1];
				assign tag_c = tag_s[j-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j] <= 1'b0;
				end else if (en) begin
					vld_s[j] <= vld_c;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j] <= den_c;
					tag_s[j] <= tag_c;
				end
			end

			for (l = 0; l < 3; l++) begin : g_lane
				logic [W-1:0] rem_c;
				logic [F:0]   q_c;
				logic [W:0]   t;
				logic [W:0]   diff;
				logic         ge;

				if (j == 0) begin : g_first
					assign rem_c = num_in[l];
					assign q_c   = '0;
					assign t     = {1'b0, rem_c};
				end else begin : g_next
					assign rem_c = rem_s[j-1][l];
					assign q_c   = q_s[j-1][l];
					assign t     = {rem_c, 1'b0};
				end

				assign diff = t - {1'b0, den_c};
				assign ge   = (t >= {1'b0, den_c});

				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[j][l] <= ge ? diff[W-1:0] : t[W-1:0];
						q_s[j][l]   <= {q_c[F-1:0], ge};
					end
				end
			end
		end
	endgenerate

	assign vld_out = vld_s[D-1];
	assign tag_out = tag_s[D-1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_out[i] = q_s[D-1][i];
		end
	end

endmodule

// ===== hdl/vector3_alu_top.sv =====
// Pipeline: an accepted item passes 2 multiply/sum stages, DATA_WIDTH
// square-root stages, FRAC_BITS + 1 divide stages and the output register.
// Throughput: one item per cycle; a stalled output freezes every stage at once.
// Reset (arst_n low) empties the pipe; payload registers are not cleared.
module vector3_alu_top import v3a_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CMD_W-1:0]             command,
	input  logic signed [DATA_WIDTH-1:0] a_x,
	input  logic signed [DATA_WIDTH-1:0] a_y,
	input  logic signed [DATA_WIDTH-1:0] a_z,
	input  logic signed [DATA_WIDTH-1:0] b_x,
	input  logic signed [DATA_WIDTH-1:0] b_y,
	input  logic signed [DATA_WIDTH-1:0] b_z,
	input  logic signed [DATA_WIDTH-1:0] scale,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] r_x,
	output logic signed [DATA_WIDTH-1:0] r_y,
	output logic signed [DATA_WIDTH-1:0] r_z,
	output logic signed [DATA_WIDTH-1:0] scalar_out,
	output logic                         fault
);

`include "vector3_alu_top_defines.svh"

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int TW1 = CMD_W + 1 + 7*W + 3;
	localparam int TW2 = CMD_W + 1 + 5*W + 3;
	localparam int NW  = (F + 2 > W + 1) ? F + 2 : W + 1;

	function automatic logic [W:0] sat_n(input logic signed [NW-1:0] v);
		logic         ovf;
		logic [W-1:0] res;
		ovf = (v[NW-1:W-1] != {(NW-W+1){v[NW-1]}});
		if (!ovf) begin
			res = v[W-1:0];
		end else if (v[NW-1]) begin
			res = {1'b1, {(W-1){1'b0}}};
		end else begin
			res = {1'b0, {(W-1){1'b1}}};
		end
		return {ovf, res};
	endfunction

	logic adv;
	logic out_vld_q;

	// whole pipe moves unless the output item is held
	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	// front: multiply, add, sum and saturate
	logic signed [W-1:0] a_v [3];
	logic signed [W-1:0] b_v [3];
	ctl_t                ctl_f;
	logic signed [W-1:0] r_f [3];
	logic signed [W-1:0] sc_f;
	logic [2*W-1:0]      sq_f;
	logic [W-1:0]        mag_f [3];
	logic [2:0]          sgn_f;

	assign a_v[0] = a_x;
	assign a_v[1] = a_y;
	assign a_v[2] = a_z;
	assign b_v[0] = b_x;
	assign b_v[1] = b_y;
	assign b_v[2] = b_z;

	v3a_front #(.W(W), .F(F)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (in_valid),
		.cmd    (command),
		.a      (a_v),
		.b      (b_v),
		.s      (scale),
		.ctl    (ctl_f),
		.r      (r_f),
		.sc     (sc_f),
		.sq     (sq_f),
		.mag    (mag_f),
		.sgn    (sgn_f)
	);

	// square root of the sum of squares
	logic [TW1-1:0] tag1_in;
	logic [TW1-1:0] tag1_out;
	logic           vld_r;
	logic [W-1:0]   root_r;

	assign tag1_in = {ctl_f.cmd, ctl_f.fault, r_f[0], r_f[1], r_f[2], sc_f,
		mag_f[0], mag_f[1], mag_f[2], sgn_f};

	v3a_sqrt #(.W(W), .TW(TW1)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (ctl_f.vld),
		.n_in     (sq_f),
		.tag_in   (tag1_in),
		.vld_out  (vld_r),
		.root_out (root_r),
		.tag_out  (tag1_out)
	);

	logic [CMD_W-1:0]    cmd_r;
	logic                flt_r;
	logic signed [W-1:0] rx_r, ry_r, rz_r, sc_r;
	logic [W-1:0]        mag_r [3];
	logic [2:0]          sgn_r;

	assign {cmd_r, flt_r, rx_r, ry_r, rz_r, sc_r, mag_r[0], mag_r[1], mag_r[2], sgn_r}
		= tag1_out;

	// divide each magnitude by the length
	logic [TW2-1:0] tag2_in;
	logic [TW2-1:0] tag2_out;
	logic           vld_d;
	logic [F:0]     quo_d [3];

	assign tag2_in = {cmd_r, flt_r, rx_r, ry_r, rz_r, sc_r, root_r, sgn_r};

	v3a_div #(.W(W), .F(F), .TW(TW2)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (vld_r),
		.den_in  (root_r),
		.num_in  (mag_r),
		.tag_in  (tag2_in),
		.vld_out (vld_d),
		.quo_out (quo_d),
		.tag_out (tag2_out)
	);

	logic [CMD_W-1:0]    cmd_d;
	logic                flt_d;
	logic signed [W-1:0] r_d [3];
	logic signed [W-1:0] sc_d;
	logic [W-1:0]        len_d;
	logic [2:0]          sgn_d;

	assign {cmd_d, flt_d, r_d[0], r_d[1], r_d[2], sc_d, len_d, sgn_d} = tag2_out;

	// final selection: length saturation, signed normalized components
	logic signed [NW-1:0] qe [3];
	logic signed [NW-1:0] qs [3];
	logic [W:0]           qsat [3];
	logic signed [W-1:0]  r_o [3];
	logic signed [W-1:0]  sc_o;
	logic                 flt_o;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i]   = {{(NW-F-1){1'b0}}, quo_d[i]};
			qs[i]   = sgn_d[i] ? -qe[i] : qe[i];
			qsat[i] = sat_n(qs[i]);
			r_o[i]  = r_d[i];
		end
		sc_o  = sc_d;
		flt_o = flt_d;
		case (cmd_d)
			CMD_LEN: begin
				if (len_d[W-1]) begin
					sc_o  = {1'b0, {(W-1){1'b1}}};
					flt_o = 1'b1;
				end else begin
					sc_o = len_d;
				end
			end
			CMD_NORM: begin
				if (len_d == '0) begin
					for (int i = 0; i < 3; i++) begin
						r_o[i] = '0;
					end
					flt_o = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						r_o[i] = qsat[i][W-1:0];
					end
					flt_o = qsat[0][W] | qsat[1][W] | qsat[2][W];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_x        <= r_o[0];
			r_y        <= r_o[1];
			r_z        <= r_o[2];
			scalar_out <= sc_o;
			fault      <= flt_o;
		end
	end

	assign out_valid = out_vld_q;

	// checks
	`V3A_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while output held")
	`V3A_ASSERT_NOW(a_empty_takes_input, !out_valid, in_ready, "input refused with empty output")
	`V3A_ASSERT_NOW(a_one_result_kind, out_valid, scalar_out == '0 || (r_x == '0 && r_y == '0 && r_z == '0), "vector and scalar result both set")

endmodule

// ===== tb/sv/tb_vector3_alu_top.sv =====
module tb_vector3_alu_top;
	import v3a_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int LATENCY = DW + FB + 3;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic signed [DW-1:0] ax, ay, az, bx, by, bz, s;
	} op_item_t;

	typedef struct {
		logic signed [DW-1:0] rx, ry, rz, sc;
		logic flt;
	} vec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic signed [DW-1:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [DW-1:0] b_x = '0, b_y = '0, b_z = '0, scale = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] r_x, r_y, r_z, scalar_out;
	logic fault;

	op_item_t pending_ops[$];
	vec_result_t expected_results[$];
	int errors = 0;
	bit stim_done = 0;
	// sender pause and receiver hold-off requests
	bit drain_req = 0;
	int hold_cycles = 0;
	// input item taken at the last rising edge
	bit in_taken = 0;

	vector3_alu_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (.*);

	always #1 clk = ~clk;

	// saturate to the signed output range
	function automatic logic signed [DW-1:0] sat(input logic signed [127:0] v, inout logic f);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			f = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			f = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic logic [127:0] isqrt(input logic [127:0] n);
		logic [127:0] res, bitv;
		res = 0;
		bitv = 128'd1 << 126;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// expected output of one operation
	function automatic vec_result_t compute_vector_op(input op_item_t it);
		vec_result_t r;
		logic signed [127:0] a[3], b[3], acc, q;
		logic [127:0] sq, len, m;
		logic f;
		f = 1'b0;
		r.rx = '0; r.ry = '0; r.rz = '0; r.sc = '0;
		a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
		b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
		case (it.cmd)
			CMD_ADD: begin
				r.rx = sat(a[0] + b[0], f); r.ry = sat(a[1] + b[1], f);
				r.rz = sat(a[2] + b[2], f);
			end
			CMD_SUB: begin
				r.rx = sat(a[0] - b[0], f); r.ry = sat(a[1] - b[1], f);
				r.rz = sat(a[2] - b[2], f);
			end
			CMD_DOT: begin
				// exact sum then floor shift
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.sc = sat(acc >>> FB, f);
			end
			CMD_SCALE: begin
				r.rx = sat((a[0] * it.s) >>> FB, f);
				r.ry = sat((a[1] * it.s) >>> FB, f);
				r.rz = sat((a[2] * it.s) >>> FB, f);
			end
			CMD_LEN, CMD_NORM: begin
				sq = 0;
				for (int i = 0; i < 3; i++) begin
					m = a[i] < 0 ? -a[i] : a[i];
					sq += m * m;
				end
				len = isqrt(sq);
				if (it.cmd == CMD_LEN) begin
					r.sc = sat($signed(len), f);
				end else if (len == 0) begin
					f = 1'b1;
				end else begin
					// truncate toward zero on magnitude
					for (int i = 0; i < 3; i++) begin
						m = a[i] < 0 ? -a[i] : a[i];
						q = $signed((m << FB) / len);
						if (a[i] < 0) q = -q;
						case (i)
							0: r.rx = sat(q, f);
							1: r.ry = sat(q, f);
							default: r.rz = sat(q, f);
						endcase
					end
				end
			end
			default: ;
		endcase
		r.flt = f;
		return r;
	endfunction

	function automatic logic signed [DW-1:0] rand_val();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return $signed($urandom_range(0, 255)) - 128;
			4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			5: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// record the input handshake for the driver
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
	end

	// driver: offers pending items at the falling edge
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0 &&
					!(drain_req && expected_results.size() > 0)) begin
					op_item_t it;
					it = pending_ops.pop_front();
					command <= it.cmd;
					a_x <= it.ax; a_y <= it.ay; a_z <= it.az;
					b_x <= it.bx; b_y <= it.by; b_z <= it.bz; scale <= it.s;
					in_valid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready pattern, with an occasional long hold-off
	int recv_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_gap <= gap_len();
			end
		end
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				op_item_t it;
				it.cmd = command;
				it.ax = a_x; it.ay = a_y; it.az = a_z;
				it.bx = b_x; it.by = b_y; it.bz = b_z; it.s = scale;
				expected_results.push_back(compute_vector_op(it));
			end
			if (out_valid && out_ready) begin
				vec_result_t e;
				if (expected_results.size() == 0) begin
					$error("unexpected result item");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (r_x !== e.rx) begin
						$error("r_x exp %h got %h", e.rx, r_x); errors++;
					end
					if (r_y !== e.ry) begin
						$error("r_y exp %h got %h", e.ry, r_y); errors++;
					end
					if (r_z !== e.rz) begin
						$error("r_z exp %h got %h", e.rz, r_z); errors++;
					end
					if (scalar_out !== e.sc) begin
						$error("scalar_out exp %h got %h", e.sc, scalar_out); errors++;
					end
					if (fault !== e.flt) begin
						$error("fault exp %b got %b", e.flt, fault); errors++;
					end
				end
			end
		end
	end

	task automatic add_op(input logic [CMD_W-1:0] c, input logic signed [DW-1:0] ax, ay, az,
		bx, by, bz, s);
		op_item_t it;
		it.cmd = c; it.ax = ax; it.ay = ay; it.az = az;
		it.bx = bx; it.by = by; it.bz = bz; it.s = s;
		pending_ops.push_back(it);
	endtask

	localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
	localparam logic signed [DW-1:0] MINV = 32'sh80000000;
	localparam logic signed [DW-1:0] ONE = 32'sh00010000;

	initial begin
		op_item_t it;
		// directed: extremes, each operation, zero normalize, unused codes
		add_op(CMD_ADD, MAXV, MINV, ONE, ONE, MINV, -ONE, 0);
		add_op(CMD_SUB, MINV, MAXV, 0, ONE, MINV, MAXV, 0);
		add_op(CMD_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0);
		add_op(CMD_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0);
		add_op(CMD_DOT, ONE, -ONE, 3, -5, 7, 1, 0);
		add_op(CMD_SCALE, MAXV, MINV, -1, 0, 0, 0, MINV);
		add_op(CMD_SCALE, ONE, -ONE, -3, 0, 0, 0, 32'sh8000);
		add_op(CMD_LEN, MINV, MINV, MINV, 0, 0, 0, 0);
		add_op(CMD_LEN, 3, 4, 0, 0, 0, 0, 0);
		add_op(CMD_NORM, 0, 0, 0, 1, 2, 3, 4);
		add_op(CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
		add_op(CMD_NORM, MINV, 0, 0, 0, 0, 0, 0);
		add_op(CMD_NORM, -3, 4, 0, 0, 0, 0, 0);
		add_op(CMD_NORM, MAXV, MAXV, MINV, 0, 0, 0, 0);
		add_op(3'd6, MAXV, 1, 2, 3, 4, 5, 6);
		add_op(3'd7, -1, -1, -1, -1, -1, -1, -1);
		for (int n = 0; n < 2000; n++) begin
			it.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			it.ax = rand_val(); it.ay = rand_val(); it.az = rand_val();
			it.bx = rand_val(); it.by = rand_val(); it.bz = rand_val();
			it.s = rand_val();
			pending_ops.push_back(it);
		end
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		// long receiver hold-off while the sender keeps offering
		wait (pending_ops.size() < 1500);
		@(negedge clk) hold_cycles <= 200;
		// sender pauses until everything drains
		wait (pending_ops.size() < 800);
		drain_req = 1;
		wait (expected_results.size() == 0);
		drain_req = 0;
		wait (pending_ops.size() == 0 && !in_valid);
		stim_done = 1;
		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
